// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a caller message
`define MDFS_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same, with a stock message
`define MDFS_ASSERT(name, clk, rst_n, prop) \
  `MDFS_ASSERT_MSG(name, clk, rst_n, prop, "port check failed")

`endif

// File: rtl/mdfs_pkg.sv
`timescale 1ns / 1ps

package mdfs_pkg;

  localparam int unsigned GRID_SIDE = 8;
  localparam int unsigned COORD_W   = 3;
  localparam int unsigned POS_W     = 2 * COORD_W;
  localparam int unsigned CELLS     = 1 << POS_W;
  localparam int unsigned DEPTH_W   = POS_W + 1;
  localparam int unsigned DIR_W     = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ENTRY_W   = DIR_W + POS_W;

  localparam logic [DIR_W-1:0]   DIR_DONE = 3'd4;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_WALL   = 2'd1,
    KIND_SOURCE = 2'd2,
    KIND_DEST   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] pos;
  } nbr_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic advance;
    logic pop;
    logic pop_load;
    logic push;
    logic found;
    logic mark_step;
    logic mark_check;
    logic mark_write;
    logic emit;
    logic not_found;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dir_done;
    logic depth_one;
    logic nb_ok;
    logic is_open;
    logic is_dest;
    logic mark_done;
    logic out_free;
    logic emit_last;
  } status_t;

  // neighbor of a cell, ok low when it falls off a grid of the given side
  function automatic nbr_t neighbour(input logic [POS_W-1:0] pos, input dir_e dir,
                                     input logic [COORD_W:0] side);
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [COORD_W:0]   r1;
    logic [COORD_W:0]   c1;
    nbr_t               n;
    r  = pos[POS_W-1:COORD_W];
    c  = pos[COORD_W-1:0];
    r1 = {1'b0, r} + 1'b1;
    c1 = {1'b0, c} + 1'b1;
    n.ok  = 1'b0;
    n.pos = pos;
    case (dir)
      DIR_DOWN: begin
        n.ok  = r1 < side;
        n.pos = {r1[COORD_W-1:0], c};
      end
      DIR_UP: begin
        n.ok  = r != '0;
        n.pos = {r - 1'b1, c};
      end
      DIR_RIGHT: begin
        n.ok  = c1 < side;
        n.pos = {r, c1[COORD_W-1:0]};
      end
      DIR_LEFT: begin
        n.ok  = c != '0;
        n.pos = {r, c - 1'b1};
      end
      default: begin
        n.ok  = 1'b0;
        n.pos = pos;
      end
    endcase
    return n;
  endfunction

endpackage

// File: rtl/mdfs_ram.sv
`timescale 1ns / 1ps

module mdfs_ram #(
  parameter int unsigned WIDTH = mdfs_pkg::KIND_W,
  parameter int unsigned DEPTH = mdfs_pkg::CELLS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mdfs_dp.sv
`timescale 1ns / 1ps

module mdfs_dp #(
  parameter int unsigned GRID_SIDE = mdfs_pkg::GRID_SIDE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mdfs_pkg::cmd_t                    cmd_i,
  output mdfs_pkg::status_t                 status_o,
  input  logic [mdfs_pkg::COORD_W-1:0]      row_i,
  input  logic [mdfs_pkg::COORD_W-1:0]      col_i,
  input  logic [mdfs_pkg::KIND_W-1:0]       cell_kind_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [mdfs_pkg::COORD_W-1:0]      path_row_o,
  output logic [mdfs_pkg::COORD_W-1:0]      path_col_o,
  output logic                              found_o,
  output logic                              last_o
);

  localparam int unsigned PW = mdfs_pkg::POS_W;
  localparam int unsigned DW = mdfs_pkg::DEPTH_W;
  localparam int unsigned CW = mdfs_pkg::COORD_W;
  localparam logic [CW:0] SIDE_LIM = (CW + 1)'(GRID_SIDE);

  logic [PW-1:0]                  top_pos_q, nb_q, prev_pos_q, src_q;
  logic [mdfs_pkg::DIR_W-1:0]     top_dir_q, mark_idx_q;
  logic [DW-1:0]                  depth_q, emit_idx_q;
  logic [1:0]                     dd_q;
  logic                           mark_q, mark_ok_q;
  logic [mdfs_pkg::CELLS-1:0]     on_path_q, exhausted_q;
  logic                           out_valid_q;
  logic [CW-1:0]                  out_row_q, out_col_q;
  logic                           out_found_q, out_last_q;

  mdfs_pkg::nbr_t                 step_nb, mark_nb;
  logic [PW-1:0]                  in_pos;
  logic                           in_ok;
  logic [DW-1:0]                  depth_m1, depth_m2, emit_p2;

  logic                           g_we;
  logic [PW-1:0]                  g_waddr, g_raddr;
  logic [mdfs_pkg::KIND_W-1:0]    g_wdata, g_rdata;

  logic                           s_we;
  logic [PW-1:0]                  s_waddr, s_raddr;
  logic [mdfs_pkg::ENTRY_W-1:0]   s_wdata, s_rdata;
  logic [PW-1:0]                  stack_pos;
  logic                           emit_last, emit_wall;
  logic [PW-1:0]                  emit_pos;

  assign step_nb  = mdfs_pkg::neighbour(top_pos_q, mdfs_pkg::dir_e'(top_dir_q[1:0]),
                                        SIDE_LIM);
  assign mark_nb  = mdfs_pkg::neighbour(prev_pos_q, mdfs_pkg::dir_e'(mark_idx_q[1:0]),
                                        SIDE_LIM);
  assign in_pos   = {row_i, col_i};
  assign in_ok    = ({1'b0, row_i} < SIDE_LIM) && ({1'b0, col_i} < SIDE_LIM);
  assign depth_m1 = depth_q - 1'b1;
  assign depth_m2 = depth_q - DW'(2);
  assign emit_p2  = emit_idx_q + DW'(2);

  assign stack_pos = s_rdata[PW-1:0];
  assign emit_last = emit_idx_q == depth_m1;
  assign emit_wall = emit_p2 < depth_q;
  assign emit_pos  = emit_last ? top_pos_q : stack_pos;

  // grid write port: cell load, wall marking, source reopen
  always_comb begin
    g_we    = 1'b0;
    g_waddr = in_pos;
    g_wdata = cell_kind_i;
    if (cmd_i.load) begin
      g_we = in_ok;
    end else if (cmd_i.mark_write) begin
      g_we    = mark_q;
      g_waddr = prev_pos_q;
      g_wdata = mdfs_pkg::KIND_WALL;
    end else if (cmd_i.emit) begin
      g_we    = emit_wall;
      g_waddr = stack_pos;
      g_wdata = mdfs_pkg::KIND_WALL;
    end else if (cmd_i.not_found) begin
      g_we    = 1'b1;
      g_waddr = src_q;
      g_wdata = mdfs_pkg::KIND_OPEN;
    end
  end

  assign g_raddr = cmd_i.mark_step ? mark_nb.pos : step_nb.pos;

  mdfs_ram #(
    .WIDTH (mdfs_pkg::KIND_W),
    .DEPTH (mdfs_pkg::CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // stack holds every entry below the top, top lives in registers
  assign s_we    = cmd_i.push;
  assign s_waddr = depth_m1[PW-1:0];
  assign s_wdata = {top_dir_q, top_pos_q};
  assign s_raddr = cmd_i.pop ? depth_m2[PW-1:0] : emit_idx_q[PW-1:0];

  mdfs_ram #(
    .WIDTH (mdfs_pkg::ENTRY_W),
    .DEPTH (mdfs_pkg::CELLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign status_o.dir_done  = top_dir_q == mdfs_pkg::DIR_DONE;
  assign status_o.depth_one = depth_q == DW'(1);
  assign status_o.nb_ok     = step_nb.ok && !on_path_q[step_nb.pos];
  assign status_o.is_open   = (g_rdata == mdfs_pkg::KIND_OPEN) && !exhausted_q[nb_q];
  assign status_o.is_dest   = g_rdata == mdfs_pkg::KIND_DEST;
  assign status_o.mark_done = mark_idx_q == {1'b0, dd_q};
  assign status_o.out_free  = !out_valid_q;
  assign status_o.emit_last = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      depth_q     <= '0;
      on_path_q   <= '0;
      exhausted_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && in_ok && (cell_kind_i == mdfs_pkg::KIND_SOURCE)) begin
        src_q <= in_pos;
      end
      if (cmd_i.init) begin
        on_path_q   <= {{(mdfs_pkg::CELLS - 1){1'b0}}, 1'b1} << src_q;
        exhausted_q <= '0;
        depth_q     <= DW'(1);
      end
      if (cmd_i.pop) begin
        exhausted_q[top_pos_q] <= 1'b1;
        on_path_q[top_pos_q]   <= 1'b0;
        depth_q                <= depth_m1;
      end
      if (cmd_i.push) begin
        on_path_q[nb_q] <= 1'b1;
        depth_q         <= depth_q + 1'b1;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit || cmd_i.not_found) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      top_pos_q <= src_q;
      top_dir_q <= '0;
    end
    if (cmd_i.advance) begin
      top_dir_q <= top_dir_q + 1'b1;
      nb_q      <= step_nb.pos;
    end
    if (cmd_i.pop_load) begin
      top_pos_q <= stack_pos;
      top_dir_q <= s_rdata[mdfs_pkg::ENTRY_W-1:PW];
    end
    if (cmd_i.push) begin
      top_pos_q <= nb_q;
      top_dir_q <= '0;
    end
    if (cmd_i.found) begin
      // direction that reached the destination
      prev_pos_q <= top_pos_q;
      dd_q       <= top_dir_q[1:0] - 1'b1;
      mark_idx_q <= '0;
      mark_q     <= 1'b0;
    end
    if (cmd_i.mark_step) begin
      mark_ok_q  <= mark_nb.ok && !on_path_q[mark_nb.pos];
      mark_idx_q <= mark_idx_q + 1'b1;
    end
    if (cmd_i.mark_check && mark_ok_q && (g_rdata == mdfs_pkg::KIND_OPEN)) begin
      mark_q <= 1'b1;
    end
    if (cmd_i.mark_write) begin
      emit_idx_q <= '0;
    end
    if (cmd_i.emit) begin
      emit_idx_q  <= emit_idx_q + 1'b1;
      out_row_q   <= emit_pos[PW-1:CW];
      out_col_q   <= emit_pos[CW-1:0];
      out_found_q <= 1'b1;
      out_last_q  <= emit_last;
    end
    if (cmd_i.not_found) begin
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_found_q <= 1'b0;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_row_o  = out_row_q;
  assign path_col_o  = out_col_q;
  assign found_o     = out_found_q;
  assign last_o      = out_last_q;

endmodule

// File: rtl/mdfs_ctrl.sv
`timescale 1ns / 1ps

module mdfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_cell_i,
  output logic              in_stall_o,
  input  mdfs_pkg::status_t status_i,
  output mdfs_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP,
    ST_POP,
    ST_CHECK,
    ST_MARK_ISSUE,
    ST_MARK_CHECK,
    ST_MARK_WRITE,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_NOT_FOUND
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_cell_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.dir_done) begin
          cmd_o.pop = 1'b1;
          state_d   = status_i.depth_one ? ST_NOT_FOUND : ST_POP;
        end else begin
          cmd_o.advance = 1'b1;
          if (status_i.nb_ok) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_STEP;
      end
      ST_CHECK: begin
        if (status_i.is_dest) begin
          cmd_o.push  = 1'b1;
          cmd_o.found = 1'b1;
          state_d     = ST_MARK_ISSUE;
        end else begin
          cmd_o.push = status_i.is_open;
          state_d    = ST_STEP;
        end
      end
      ST_MARK_ISSUE: begin
        if (status_i.mark_done) begin
          state_d = ST_MARK_WRITE;
        end else begin
          cmd_o.mark_step = 1'b1;
          state_d         = ST_MARK_CHECK;
        end
      end
      ST_MARK_CHECK: begin
        cmd_o.mark_check = 1'b1;
        state_d          = ST_MARK_ISSUE;
      end
      ST_MARK_WRITE: begin
        cmd_o.mark_write = 1'b1;
        state_d          = ST_EMIT_READ;
      end
      ST_EMIT_READ: begin
        if (status_i.out_free) begin
          state_d = ST_EMIT_LOAD;
        end
      end
      ST_EMIT_LOAD: begin
        cmd_o.emit = 1'b1;
        state_d    = status_i.emit_last ? ST_IDLE : ST_EMIT_READ;
      end
      ST_NOT_FOUND: begin
        if (status_i.out_free) begin
          cmd_o.not_found = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= state_d != ST_IDLE;
    end
  end

  assign in_stall_o = stall_q;

endmodule

// File: rtl/maze_dfs_path_finder.sv
`timescale 1ns / 1ps
// sequence: each cell transfer loads its cell; the last cell starts the search with a setup state,
//   then a step per neighbor, plus a check state for a neighbor inside the grid and off the
//   path, and a step and a pop state per backtrack; a hit then runs the wall marking and an emit
//   read and load per path result, a miss sends its single result; results wait while the output stalls
// throughput: one cell per cycle while loading; input stalls from the last cell to the final result
// reset: asynchronous active low; clears control, source position and path flags, not the grid
module maze_dfs_path_finder #(
  parameter int unsigned GRID_SIDE = mdfs_pkg::GRID_SIDE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mdfs_pkg::COORD_W-1:0]  row_i,
  input  logic [mdfs_pkg::COORD_W-1:0]  col_i,
  input  logic [mdfs_pkg::KIND_W-1:0]   cell_kind_i,
  input  logic                          last_cell_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mdfs_pkg::COORD_W-1:0]  path_row_o,
  output logic [mdfs_pkg::COORD_W-1:0]  path_col_o,
  output logic                          found_o,
  output logic                          last_o
);

  // commands from the sequencer, status back from the datapath
  mdfs_pkg::cmd_t    cmd;
  mdfs_pkg::status_t status;

  // sequencer: load, search, backtrack, mark and emit phases
  mdfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_cell_i (last_cell_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: grid ram, position stack ram, path flags and the result register
  // the result register frees the input side once the final transfer is queued
  mdfs_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_kind_i (cell_kind_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .path_row_o  (path_row_o),
    .path_col_o  (path_col_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/mdfs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mdfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [mdfs_pkg::COORD_W-1:0]  row_i,
  input logic [mdfs_pkg::COORD_W-1:0]  col_i,
  input logic [mdfs_pkg::KIND_W-1:0]   cell_kind_i,
  input logic                          last_cell_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mdfs_pkg::COORD_W-1:0]  path_row_o,
  input logic [mdfs_pkg::COORD_W-1:0]  path_col_o,
  input logic                          found_o,
  input logic                          last_o
);

  // stalled result holds
  `MDFS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(path_row_o) && $stable(path_col_o) && $stable(found_o) && $stable(last_o))

  // a miss is a single zero-coordinate final result
  `MDFS_ASSERT(a_miss_shape, clk_i, rst_ni, out_valid_o && !found_o |-> last_o && path_row_o == 3'd0 && path_col_o == 3'd0)

  // the last cell starts the search and blocks input
  `MDFS_ASSERT(a_search_blocks, clk_i, rst_ni, in_valid_i && !in_stall_o && last_cell_i |=> in_stall_o)

  // input stays blocked while a path is still being sent
  `MDFS_ASSERT(a_path_blocks, clk_i, rst_ni, out_valid_o && !out_stall_i && found_o && !last_o |=> in_stall_o)

endmodule

bind maze_dfs_path_finder mdfs_checker u_checker (.*);

// File: sim/maze_dfs_path_finder_test.sv
`timescale 1ns / 1ps

module maze_dfs_path_finder_test;
  import mdfs_pkg::*;

  localparam int ITEMS       = 450;
  localparam int STUCK_LIMIT = 10000;
  localparam int TAIL_CYCLES = 64;

  // one cell write as it crosses the input channel
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    kind_e              kind;
    logic               last;
  } cell_write_t;

  // one path position as it leaves the block
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               found;
    logic               last;
  } path_step_t;

  // keeps a private copy of the grid, replays the search on every
  // start transfer and holds the path positions still to come
  class maze_scoreboard;
    logic [KIND_W-1:0] grid [CELLS];
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  trail [CELLS];
    int                tried [CELLS];
    bit                on_trail [CELLS];
    bit                dead [CELLS];
    int                trail_len;
    path_step_t        path_steps_due [$];
    int                mismatches;

    function new();
      start_pos  = '0;
      trail_len  = 0;
      mismatches = 0;
      foreach (grid[i]) grid[i] = KIND_OPEN;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // neighbor in one of the four directions, zero when off the grid
    function bit adjacent(input logic [POS_W-1:0] pos, input int d,
                          output logic [POS_W-1:0] nb);
      int r;
      int c;
      r = int'(pos[POS_W-1:COORD_W]);
      c = int'(pos[COORD_W-1:0]);
      case (dir_e'(d))
        DIR_DOWN:  r = r + 1;
        DIR_UP:    r = r - 1;
        DIR_RIGHT: c = c + 1;
        default:   c = c - 1;
      endcase
      nb = {r[COORD_W-1:0], c[COORD_W-1:0]};
      return r >= 0 && c >= 0 && r < int'(GRID_SIDE) && c < int'(GRID_SIDE);
    endfunction

    function void push_cell(input logic [POS_W-1:0] pos);
      if (trail_len < CELLS) begin
        trail[trail_len] = pos;
        tried[trail_len] = 0;
        on_trail[pos]    = 1'b1;
        trail_len++;
      end
    endfunction

    // depth-first walk from the start cell, then the wall marking and the
    // list of positions the block has to send
    function void solve_maze();
      int               top;
      int               d;
      int               dd;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] nb;
      logic [POS_W-1:0] prev;
      bit               hit;
      bit               mark;
      path_step_t       s;
      hit  = 1'b0;
      mark = 1'b0;
      foreach (on_trail[i]) begin
        on_trail[i] = 1'b0;
        dead[i]     = 1'b0;
      end
      trail_len = 0;
      push_cell(start_pos);
      while (trail_len > 0 && !hit) begin
        top = trail_len - 1;
        pos = trail[top];
        d   = tried[top];
        if (d >= 4) begin
          // every direction tried: back out, the cell stays usable only as
          // a dead end from now on
          dead[pos]     = 1'b1;
          on_trail[pos] = 1'b0;
          trail_len--;
        end else begin
          tried[top] = d + 1;
          if (adjacent(pos, d, nb) && !on_trail[nb]) begin
            if (grid[nb] == KIND_OPEN && !dead[nb]) begin
              push_cell(nb);
            end else if (grid[nb] == KIND_DEST) begin
              push_cell(nb);
              hit = 1'b1;
            end
          end
        end
      end
      if (!hit) begin
        grid[start_pos] = KIND_OPEN;
        s.row   = '0;
        s.col   = '0;
        s.found = 1'b0;
        s.last  = 1'b1;
        path_steps_due.insert(path_steps_due.size(), s);
      end else begin
        if (trail_len >= 2) begin
          // the cell before the destination turns to wall only when it
          // looked at an open side cell first
          prev = trail[trail_len-2];
          dd   = tried[trail_len-2] - 1;
          for (int i = 0; i < dd && i < 4; i++) begin
            if (adjacent(prev, i, nb) && grid[nb] == KIND_OPEN && !on_trail[nb]) mark = 1'b1;
          end
          for (int j = 0; j + 2 < trail_len; j++) grid[trail[j]] = KIND_WALL;
          if (mark) grid[prev] = KIND_WALL;
        end
        for (int j = 0; j < trail_len; j++) begin
          s.row   = trail[j][POS_W-1:COORD_W];
          s.col   = trail[j][COORD_W-1:0];
          s.found = 1'b1;
          s.last  = (j == trail_len - 1);
          path_steps_due.insert(path_steps_due.size(), s);
        end
      end
      trail_len = 0;
    endfunction

    function void note_cell(input cell_write_t w);
      if (w.row < GRID_SIDE && w.col < GRID_SIDE) begin
        grid[{w.row, w.col}] = w.kind;
        if (w.kind == KIND_SOURCE) start_pos = {w.row, w.col};
      end
      if (w.last) solve_maze();
    endfunction

    task check_result(input path_step_t got);
      path_step_t want;
      if (path_steps_due.size() == 0) begin
        report($sformatf("result with nothing due: row %0d col %0d found %0b last %0b",
                         got.row, got.col, got.found, got.last));
      end else begin
        want = path_steps_due.pop_front();
        if (got.row !== want.row)
          report($sformatf("path_row %0d, want %0d", got.row, want.row));
        if (got.col !== want.col)
          report($sformatf("path_col %0d, want %0d", got.col, want.col));
        if (got.found !== want.found)
          report($sformatf("found %0b, want %0b", got.found, want.found));
        if (got.last !== want.last)
          report($sformatf("last %0b, want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [KIND_W-1:0]  cell_kind;
  logic               last_cell;
  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] path_row;
  logic [COORD_W-1:0] path_col;
  logic               found;
  logic               last;

  maze_scoreboard sb;
  cell_write_t    maze_cells [$];
  int             send_idle_pct;
  int             stall_pct;
  int             random_sent;

  maze_dfs_path_finder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .row_i       (row),
    .col_i       (col),
    .cell_kind_i (cell_kind),
    .last_cell_i (last_cell),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .path_row_o  (path_row),
    .path_col_o  (path_col),
    .found_o     (found),
    .last_o      (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // random row or column inside the grid
  function automatic logic [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom_range(0, GRID_SIDE - 1));
  endfunction

  // idle mix per phase: quiet, sender gaps, receiver stalls, both light
  task automatic set_phase(input int p);
    case (p)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 72; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 72; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  // receiver side: stall decided fresh every cycle
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= roll(stall_pct);
    end
  end

  // result monitor
  initial begin
    path_step_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.row   = path_row;
        got.col   = path_col;
        got.found = found;
        got.last  = last;
        sb.check_result(got);
      end
    end
  end

  // ends the run when no transfer happens on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_cell(input cell_write_t w);
    while (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    row       <= w.row;
    col       <= w.col;
    cell_kind <= w.kind;
    last_cell <= w.last;
    do @(posedge clk); while (in_stall);
    sb.note_cell(w);
    @(negedge clk);
  endtask

  task automatic send_maze();
    foreach (maze_cells[i]) send_cell(maze_cells[i]);
    maze_cells.delete();
  endtask

  // hold the sender back until every position due has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.path_steps_due.size() != 0);
  endtask

  task automatic add_cell(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                          input kind_e k, input logic l);
    cell_write_t w;
    w.row  = r;
    w.col  = c;
    w.kind = k;
    w.last = l;
    maze_cells.insert(maze_cells.size(), w);
  endtask

  task automatic shuffle_cells();
    cell_write_t t;
    int          j;
    for (int i = maze_cells.size() - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      t             = maze_cells[i];
      maze_cells[i] = maze_cells[j];
      maze_cells[j] = t;
    end
  endtask

  // whole grid rewritten in random order, one destination and at most one source
  task automatic plan_full_maze();
    int    src;
    int    dst;
    int    wall_pct;
    kind_e k;
    src      = $urandom_range(0, CELLS - 1);
    dst      = $urandom_range(0, CELLS - 1);
    wall_pct = $urandom_range(15, 45);
    for (int p = 0; p < CELLS; p++) begin
      if (p == dst) k = KIND_DEST;
      else if (p == src) k = KIND_SOURCE;
      else if (roll(wall_pct)) k = KIND_WALL;
      else k = KIND_OPEN;
      add_cell(p[POS_W-1:COORD_W], p[COORD_W-1:0], k, 1'b0);
    end
    shuffle_cells();
    maze_cells[maze_cells.size()-1].last = 1'b1;
  endtask

  // a few cells opened or walled and a fresh source and destination, all in shuffled order
  task automatic plan_edit_maze();
    int n;
    n = $urandom_range(1, 12);
    repeat (n) add_cell(rand_coord(), rand_coord(), roll(60) ? KIND_OPEN : KIND_WALL, 1'b0);
    add_cell(rand_coord(), rand_coord(), KIND_SOURCE, 1'b0);
    add_cell(rand_coord(), rand_coord(), KIND_DEST, 1'b0);
    shuffle_cells();
    maze_cells[maze_cells.size()-1].last = 1'b1;
  endtask

  // anything goes: random kinds, stray sources, extra searches midway
  task automatic plan_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) add_cell(rand_coord(), rand_coord(), kind_e'($urandom_range(0, 3)), roll(10));
    maze_cells[maze_cells.size()-1].last = 1'b1;
  endtask

  initial begin
    int pick;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    row       = '0;
    col       = '0;
    cell_kind = KIND_OPEN;
    last_cell = 1'b0;
    sb        = new();
    set_phase(0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed mazes in the top-left and bottom-right corners; every cell
    // the search looks at is written first, the rest of the grid stays unknown
    // no source written yet: search starts at the top-left corner
    add_cell(0, 0, KIND_OPEN, 1'b0);
    add_cell(1, 0, KIND_WALL, 1'b0);
    add_cell(0, 1, KIND_DEST, 1'b1);
    // boxed-in source: not found, source reopened
    add_cell(0, 1, KIND_WALL, 1'b0);
    add_cell(0, 0, KIND_SOURCE, 1'b1);
    // two sources, the later one in the far corner wins
    add_cell(0, 0, KIND_SOURCE, 1'b0);
    add_cell(7, 6, KIND_WALL, 1'b0);
    add_cell(6, 7, KIND_DEST, 1'b0);
    add_cell(7, 7, KIND_SOURCE, 1'b1);
    // start transfer on an open cell, path of three along the bottom row
    add_cell(6, 7, KIND_WALL, 1'b0);
    add_cell(7, 5, KIND_DEST, 1'b0);
    add_cell(6, 6, KIND_WALL, 1'b0);
    add_cell(7, 6, KIND_OPEN, 1'b1);
    send_maze();

    // first random maze defines the whole grid, later ones may edit it
    random_sent = 0;
    plan_full_maze();
    random_sent += maze_cells.size();
    send_maze();
    drain_results();

    while (random_sent < ITEMS) begin
      set_phase(random_sent * 4 / ITEMS);
      pick = $urandom_range(0, 99);
      if (pick < 25) plan_full_maze();
      else if (pick < 80) plan_edit_maze();
      else plan_noise();
      random_sent += maze_cells.size();
      send_maze();
      if (roll(25)) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
